FILE: hdl/p2a_pkg.sv
// shared widths, constants and stage types of the pressure to altitude pipeline
package p2a_pkg;

  // port fields
  localparam int IN_W  = 17;
  localparam int OUT_W = 24;

  // log2 section: normalized mantissa and squaring steps
  localparam int MANT_W   = 32;
  localparam int FRAC_W   = 32;
  localparam int EXPN_W   = 5;
  localparam int LOG_W    = EXPN_W + FRAC_W;
  localparam int SQ_STEPS = 32;

  // scaling section
  localparam int APROD_W = 51;
  localparam int BPROD_W = 46;
  localparam int YM_W    = 36;
  localparam int SH_W    = 5;

  // exp2 section: one square root per fraction bit, one root bit per stage
  localparam int EXP_ROUNDS = FRAC_W;
  localparam int ROOT_W     = 31;
  localparam int RAD_W      = 32;
  localparam int REM_W      = 33;
  localparam int SQRT_ITERS = ROOT_W;

  // altitude section
  localparam int MAG_W  = 32;
  localparam int PROD_W = 58;
  localparam int Y_W    = 28;
  localparam int YQ_W   = 57;
  localparam int Q_W    = 25;

  // log2(101325) in Q32
  localparam logic [LOG_W-1:0]  LOG2_PB    = 37'd71419424818;
  // exponent -R*Lb/(g0*M) in Q32
  localparam logic [29:0]       EXP_Q32    = 30'd817188396;
  localparam logic [ROOT_W-1:0] ONE_Q30    = 31'h4000_0000;
  // Tb/|Lb| = SCALE_NUM / SCALE_DEN centimeters
  localparam logic [25:0]       SCALE_NUM  = 26'd57630000;
  localparam logic [3:0]        SCALE_DEN  = 4'd13;
  // half of SCALE_DEN * 2^30 for round to nearest
  localparam logic [PROD_W:0]   ROUND_HALF = 59'd6979321856;
  // floor(2^32 / 13)
  localparam logic [28:0]       RECIP13    = 29'd330382099;

  typedef struct packed {
    logic             zero;
    logic [LOG_W-1:0] l;
  } log_res_t;

  typedef struct packed {
    logic [FRAC_W-1:0] f;
    logic [SH_W-1:0]   sh;
    logic              shl;
    logic              neg;
    logic              zero;
  } exp_side_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

endpackage

FILE: hdl/p2a_log2.sv
// log2 of the pressure in Q32: normalize, then one squaring step per stage
module p2a_log2 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [p2a_pkg::IN_W-1:0]    pressure_i,
  output logic                        vld_o,
  output p2a_pkg::log_res_t           res_o
);

  localparam int NR = p2a_pkg::SQ_STEPS + 1;

  logic [NR-1:0]                 vld_q;
  logic [NR-1:0]                 zero_q, zero_d;
  logic [p2a_pkg::MANT_W-1:0]    m_q    [NR];
  logic [p2a_pkg::MANT_W-1:0]    m_d    [NR];
  logic [p2a_pkg::FRAC_W-1:0]    frac_q [NR];
  logic [p2a_pkg::FRAC_W-1:0]    frac_d [NR];
  logic [p2a_pkg::EXPN_W-1:0]    k_q    [NR];
  logic [p2a_pkg::EXPN_W-1:0]    k_d    [NR];

  always_comb begin
    logic [p2a_pkg::EXPN_W-1:0]   k;
    logic [2*p2a_pkg::MANT_W-1:0] sq;
    logic [p2a_pkg::MANT_W:0]     t;
    k  = '0;
    sq = '0;
    t  = '0;
    // msb position
    for (int b = 0; b < p2a_pkg::IN_W; b++) begin
      if (pressure_i[b]) begin
        k = p2a_pkg::EXPN_W'(b);
      end
    end
    m_d[0]    = p2a_pkg::MANT_W'(pressure_i) << (5'd31 - k);
    frac_d[0] = '0;
    k_d[0]    = k;
    zero_d[0] = (pressure_i == '0);
    for (int i = 1; i < NR; i++) begin
      sq = (2*p2a_pkg::MANT_W)'(m_q[i-1]) * (2*p2a_pkg::MANT_W)'(m_q[i-1]);
      t  = sq[2*p2a_pkg::MANT_W-1:p2a_pkg::MANT_W-1];
      if (t[p2a_pkg::MANT_W]) begin
        m_d[i]    = t[p2a_pkg::MANT_W:1];
        frac_d[i] = {frac_q[i-1][p2a_pkg::FRAC_W-2:0], 1'b1};
      end else begin
        m_d[i]    = t[p2a_pkg::MANT_W-1:0];
        frac_d[i] = {frac_q[i-1][p2a_pkg::FRAC_W-2:0], 1'b0};
      end
      k_d[i]    = k_q[i-1];
      zero_d[i] = zero_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NR-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q <= zero_d;
      for (int i = 0; i < NR; i++) begin
        m_q[i]    <= m_d[i];
        frac_q[i] <= frac_d[i];
        k_q[i]    <= k_d[i];
      end
    end
  end

  assign vld_o      = vld_q[NR-1];
  assign res_o.zero = zero_q[NR-1];
  assign res_o.l    = {k_q[NR-1], frac_q[NR-1]};

endmodule

FILE: hdl/p2a_scale.sv
// distance from sea-level log2, times the exponent, split into shift and fraction
module p2a_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                vld_i,
  input  p2a_pkg::log_res_t   res_i,
  output logic                vld_o,
  output p2a_pkg::exp_side_t  side_o
);

  logic [2:0]                   vld_q;
  logic                         neg1_q, zero1_q, neg2_q, zero2_q;
  logic [p2a_pkg::LOG_W-1:0]    a1_q, a1_d;
  logic                         neg1_d;
  logic [p2a_pkg::APROD_W-1:0]  pa2_q;
  logic [p2a_pkg::BPROD_W-1:0]  pb2_q;
  p2a_pkg::exp_side_t           side3_q, side3_d;

  always_comb begin
    neg1_d = res_i.l < p2a_pkg::LOG2_PB;
    a1_d   = neg1_d ? p2a_pkg::LOG2_PB - res_i.l : res_i.l - p2a_pkg::LOG2_PB;
  end

  always_comb begin
    logic [p2a_pkg::APROD_W:0] sum;
    logic [p2a_pkg::YM_W-1:0]  ym;
    logic [3:0]                ip;
    logic [p2a_pkg::FRAC_W-1:0] fr;
    sum = (p2a_pkg::APROD_W+1)'(pa2_q)
        + (p2a_pkg::APROD_W+1)'(pb2_q[p2a_pkg::BPROD_W-1:16]);
    ym  = sum[p2a_pkg::APROD_W:16];
    ip  = ym[p2a_pkg::YM_W-1:p2a_pkg::FRAC_W];
    fr  = ym[p2a_pkg::FRAC_W-1:0];
    side3_d.neg  = neg2_q;
    side3_d.zero = zero2_q;
    if (neg2_q) begin
      // below one: shift right by ceil(y), fraction taken from one
      side3_d.shl = 1'b0;
      if (fr != '0) begin
        side3_d.sh = p2a_pkg::SH_W'(ip) + 5'd1;
        side3_d.f  = ~fr + 32'd1;
      end else begin
        side3_d.sh = p2a_pkg::SH_W'(ip);
        side3_d.f  = '0;
      end
    end else begin
      // above one: at most one left shift
      side3_d.sh  = '0;
      side3_d.shl = (ip != '0);
      side3_d.f   = fr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q  <= neg1_d;
      zero1_q <= res_i.zero;
      a1_q    <= a1_d;
      neg2_q  <= neg1_q;
      zero2_q <= zero1_q;
      pa2_q   <= p2a_pkg::APROD_W'(a1_q[p2a_pkg::LOG_W-1:16])
               * p2a_pkg::APROD_W'(p2a_pkg::EXP_Q32);
      pb2_q   <= p2a_pkg::BPROD_W'(a1_q[15:0]) * p2a_pkg::BPROD_W'(p2a_pkg::EXP_Q32);
      side3_q <= side3_d;
    end
  end

  assign vld_o  = vld_q[2];
  assign side_o = side3_q;

endmodule

FILE: hdl/p2a_exp2.sv
// 2^f in Q30: per fraction bit an optional doubling and a square root, one root bit a stage
module p2a_exp2 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  p2a_pkg::exp_side_t            side_i,
  output logic                          vld_o,
  output logic [p2a_pkg::ROOT_W-1:0]    v_o,
  output p2a_pkg::exp_side_t            side_o
);

  localparam int NS = p2a_pkg::EXP_ROUNDS * p2a_pkg::SQRT_ITERS;

  logic [NS-1:0]        vld_q;
  p2a_pkg::sqrt_st_t    st_q     [NS];
  p2a_pkg::sqrt_st_t    st_d     [NS];
  p2a_pkg::sqrt_st_t    prv_st   [NS];
  p2a_pkg::exp_side_t   side_q   [NS];
  p2a_pkg::exp_side_t   prv_side [NS];

  always_comb begin
    int                            n;
    logic [p2a_pkg::ROOT_W-1:0]    v;
    logic [p2a_pkg::RAD_W-1:0]     rad;
    logic [p2a_pkg::REM_W-1:0]     rem;
    logic [p2a_pkg::ROOT_W-1:0]    root;
    logic [p2a_pkg::REM_W+1:0]     rt, trial, diff;
    n     = 0;
    v     = '0;
    rad   = '0;
    rem   = '0;
    root  = '0;
    rt    = '0;
    trial = '0;
    diff  = '0;
    prv_st[0].rad  = '0;
    prv_st[0].rem  = '0;
    prv_st[0].root = p2a_pkg::ONE_Q30;
    prv_side[0]    = side_i;
    for (int i = 1; i < NS; i++) begin
      prv_st[i]   = st_q[i-1];
      prv_side[i] = side_q[i-1];
    end
    for (int r = 0; r < p2a_pkg::EXP_ROUNDS; r++) begin
      for (int it = 0; it < p2a_pkg::SQRT_ITERS; it++) begin
        n = r * p2a_pkg::SQRT_ITERS + it;
        if (it == 0) begin
          // new round: double on a set fraction bit, restart the root
          v    = prv_st[n].root;
          rad  = prv_side[n].f[r] ? {v, 1'b0} : {1'b0, v};
          rem  = '0;
          root = '0;
        end else begin
          rad  = prv_st[n].rad;
          rem  = prv_st[n].rem;
          root = prv_st[n].root;
        end
        rt    = {rem, rad[p2a_pkg::RAD_W-1:p2a_pkg::RAD_W-2]};
        trial = {2'b00, root, 2'b01};
        diff  = rt - trial;
        if (rt >= trial) begin
          st_d[n].rem  = diff[p2a_pkg::REM_W-1:0];
          st_d[n].root = {root[p2a_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          st_d[n].rem  = rt[p2a_pkg::REM_W-1:0];
          st_d[n].root = {root[p2a_pkg::ROOT_W-2:0], 1'b0};
        end
        st_d[n].rad = {rad[p2a_pkg::RAD_W-3:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NS; i++) begin
        st_q[i]   <= st_d[i];
        side_q[i] <= prv_side[i];
      end
    end
  end

  assign vld_o  = vld_q[NS-1];
  assign v_o    = st_q[NS-1].root;
  assign side_o = side_q[NS-1];

endmodule

FILE: hdl/p2a_alt.sv
// power term to centimeters: shift, distance from one, scale, round, divide by 13
module p2a_alt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [p2a_pkg::ROOT_W-1:0]  v_i,
  input  p2a_pkg::exp_side_t          side_i,
  output logic                        vld_o,
  output logic [p2a_pkg::OUT_W-1:0]   altitude_o
);

  logic [3:0]                  vld_q;
  logic                        below1_q, below2_q, below3_q, below4_q;
  logic                        below1_d;
  logic [p2a_pkg::MAG_W-1:0]   mag1_q, mag1_d;
  logic [p2a_pkg::PROD_W-1:0]  prod2_q;
  logic [p2a_pkg::Y_W-1:0]     y3_q, y3_d, y4_q;
  logic [p2a_pkg::YQ_W-1:0]    yq4_q;

  always_comb begin
    logic [p2a_pkg::MAG_W-1:0] r;
    logic [p2a_pkg::MAG_W-1:0] one;
    one = p2a_pkg::MAG_W'(p2a_pkg::ONE_Q30);
    if (side_i.zero) begin
      r = '0;
    end else if (side_i.neg) begin
      r = p2a_pkg::MAG_W'(v_i) >> side_i.sh;
    end else begin
      r = p2a_pkg::MAG_W'(v_i) << side_i.shl;
    end
    below1_d = r > one;
    mag1_d   = below1_d ? r - one : one - r;
  end

  always_comb begin
    logic [p2a_pkg::PROD_W:0] sum;
    sum  = (p2a_pkg::PROD_W+1)'(prod2_q) + p2a_pkg::ROUND_HALF;
    y3_d = sum[p2a_pkg::Y_W+29:30];
  end

  // quotient by 13: reciprocal estimate, low by at most one, then corrected
  always_comb begin
    logic [p2a_pkg::Q_W-1:0]   q0, q;
    logic [p2a_pkg::Q_W+3:0]   m13;
    logic [p2a_pkg::Y_W-1:0]   rm;
    q0  = yq4_q[p2a_pkg::YQ_W-1:32];
    m13 = (p2a_pkg::Q_W+4)'(q0) * (p2a_pkg::Q_W+4)'(p2a_pkg::SCALE_DEN);
    rm  = y4_q - m13[p2a_pkg::Y_W-1:0];
    q   = (rm >= p2a_pkg::Y_W'(p2a_pkg::SCALE_DEN)) ? q0 + 25'd1 : q0;
    altitude_o = below4_q ? ~q[p2a_pkg::OUT_W-1:0] + 24'd1 : q[p2a_pkg::OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      below1_q <= below1_d;
      mag1_q   <= mag1_d;
      below2_q <= below1_q;
      prod2_q  <= p2a_pkg::PROD_W'(p2a_pkg::SCALE_NUM) * p2a_pkg::PROD_W'(mag1_q);
      below3_q <= below2_q;
      y3_q     <= y3_d;
      below4_q <= below3_q;
      y4_q     <= y3_q;
      yq4_q    <= p2a_pkg::YQ_W'(y3_q) * p2a_pkg::YQ_W'(p2a_pkg::RECIP13);
    end
  end

  assign vld_o = vld_q[3];

endmodule

FILE: hdl/pressure_to_altitude.sv
// top level: barometric pressure in pascals to altitude in centimeters
//
// input channel: in_valid_i / in_stall_o carry one 17-bit unsigned pressure
// beat (pressure_pa_i, whole pascals); a beat is taken at a rising edge with
// in_valid_i high and in_stall_o low
// output channel: out_valid_o / out_stall_i carry one signed 24-bit altitude
// beat (altitude_cm_o, centimeters above mean sea level) per input beat,
// in order
// throughput: one beat per cycle while in_stall_o is low; every stage holds at
// most one beat and all stages advance together
// stages: 33 log2 stages, 3 scaling stages, the exp2 section (32 square
// roots, one root bit per stage, 992 stages) and 4 altitude stages, in
// that order
// stall: a two-entry output buffer takes finished beats; while it is full the
// whole pipeline holds and in_stall_o is high, and no beat is lost or repeated
// reset: rst_ni clears every stage valid bit and the buffer count and pointers,
// so the block comes out of reset empty and ready; the data is not reset
module pressure_to_altitude (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic        [p2a_pkg::IN_W-1:0]    pressure_pa_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [p2a_pkg::OUT_W-1:0]   altitude_cm_o
);

  localparam int OBUF_DEPTH = 2;
  localparam int OBUF_CW    = $clog2(OBUF_DEPTH + 1);

  // pipeline advance: everything moves unless the output buffer is full
  logic                        en;
  logic                        log_vld, scl_vld, exp_vld, alt_vld;
  p2a_pkg::log_res_t           log_res;
  p2a_pkg::exp_side_t          scl_side, exp_side;
  logic [p2a_pkg::ROOT_W-1:0]  exp_v;
  logic [p2a_pkg::OUT_W-1:0]   alt_data;

  // output buffer
  logic [p2a_pkg::OUT_W-1:0]   buf_q [OBUF_DEPTH];
  logic                        wr_ptr_q, rd_ptr_q;
  logic [OBUF_CW-1:0]          cnt_q, cnt_d;
  logic                        push, pop;

  assign en         = (cnt_q != OBUF_CW'(OBUF_DEPTH));
  assign in_stall_o = ~en;

  // log2(p) in Q32
  p2a_log2 u_log2 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (in_valid_i),
    .pressure_i (pressure_pa_i),
    .vld_o      (log_vld),
    .res_o      (log_res)
  );

  // exponent scaling, split into shift and fraction
  p2a_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (log_vld),
    .res_i  (log_res),
    .vld_o  (scl_vld),
    .side_o (scl_side)
  );

  // 2^fraction by repeated square roots
  p2a_exp2 u_exp2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (scl_vld),
    .side_i (scl_side),
    .vld_o  (exp_vld),
    .v_o    (exp_v),
    .side_o (exp_side)
  );

  // power term to rounded centimeters
  p2a_alt u_alt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .vld_i      (exp_vld),
    .v_i        (exp_v),
    .side_i     (exp_side),
    .vld_o      (alt_vld),
    .altitude_o (alt_data)
  );

  // finished beat enters the buffer on the same edge the pipeline advances
  assign push = en & alt_vld;
  assign pop  = (cnt_q != '0) & ~out_stall_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + OBUF_CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - OBUF_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // buffer payload needs no reset
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= alt_data;
    end
  end

  assign out_valid_o   = (cnt_q != '0);
  assign altitude_cm_o = $signed(buf_q[rd_ptr_q]);

endmodule
